// File: rtl/core/bpoc_pkg.sv
// ----------------------------------------------------------------------------
// bpoc_pkg: shared types and constants for the break-beam object counter
// Request and status codes, register indexes, configuration and item types.
// ----------------------------------------------------------------------------
package bpoc_pkg;

  localparam int unsigned LevelW = 10;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  // Request kinds carried by req_type
  typedef enum logic {
    REQ_ARM    = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_WAITING  = 3'd1,
    ST_COUNTED  = 3'd2,
    ST_COOLDOWN = 3'd3,
    ST_TAMPER   = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_ARM_DELAY_MS    = 3'd1,
    REG_MIN_BREAK_MS    = 3'd2,
    REG_MAX_BREAK_MS    = 3'd3,
    REG_COOLDOWN_MS     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LevelW-1:0] level_threshold;
    logic [MsW-1:0]    arm_delay_ms;
    logic [MsW-1:0]    min_break_ms;
    logic [MsW-1:0]    max_break_ms;
    logic [MsW-1:0]    cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [LevelW-1:0] sample_level;
    logic [TimeW-1:0]  time_ms;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [CountW-1:0] object_count;
    logic [TimeW-1:0]  break_duration;
  } result_t;

endpackage

// File: rtl/core/bpoc_if.sv
// ----------------------------------------------------------------------------
// bpoc_in_if / bpoc_out_if: valid/ready channels of the object counter
// Input channel carries request items, output channel carries results.
// ----------------------------------------------------------------------------
interface bpoc_in_if import bpoc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [LevelW-1:0] sample_level;
  logic [TimeW-1:0]  time_ms;

  modport source (output valid, output req_type, output sample_level,
                  output time_ms, input ready);
  modport sink   (input valid, input req_type, input sample_level,
                  input time_ms, output ready);
endinterface

interface bpoc_out_if import bpoc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [CountW-1:0] object_count;
  logic [TimeW-1:0]  break_duration;

  modport source (output valid, output status, output object_count,
                  output break_duration, input ready);
  modport sink   (input valid, input status, input object_count,
                  input break_duration, output ready);
endinterface

// File: rtl/core/bpoc_step.sv
// ----------------------------------------------------------------------------
// bpoc_step: session state and per-item decision logic
// Holds the session, timing and cooldown state; computes one result per item
// and commits the state update when the item advances.
// ----------------------------------------------------------------------------
module bpoc_step import bpoc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic              session_r, session_nxt;
  logic [TimeW-1:0]  arm_time_r, arm_time_nxt;
  logic              timing_r, timing_nxt;
  logic [TimeW-1:0]  break_start_r, break_start_nxt;
  logic [TimeW-1:0]  next_allowed_r, next_allowed_nxt;
  logic [CountW-1:0] counted_r, counted_nxt;

  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  duration;
  logic              in_delay;
  logic              broken;
  logic              bad_width;
  logic              cool_ok;

  // Shared arithmetic on the item
  assign elapsed   = item.time_ms - arm_time_r;
  assign duration  = item.time_ms - break_start_r;
  assign in_delay  = elapsed <= {{(TimeW-MsW){1'b0}}, cfg.arm_delay_ms};
  assign broken    = item.sample_level > cfg.level_threshold;
  assign bad_width = (duration < {{(TimeW-MsW){1'b0}}, cfg.min_break_ms}) ||
                     (duration > {{(TimeW-MsW){1'b0}}, cfg.max_break_ms});
  assign cool_ok   = item.time_ms >= next_allowed_r;

  // Decision and next state
  always_comb begin
    session_nxt      = session_r;
    arm_time_nxt     = arm_time_r;
    timing_nxt       = timing_r;
    break_start_nxt  = break_start_r;
    next_allowed_nxt = next_allowed_r;
    counted_nxt      = counted_r;
    result.status         = ST_IGNORED;
    result.break_duration = '0;

    if (item.req_type == REQ_ARM) begin
      session_nxt      = 1'b1;
      arm_time_nxt     = item.time_ms;
      timing_nxt       = 1'b0;
      break_start_nxt  = '0;
      next_allowed_nxt = '0;
      counted_nxt      = '0;
      result.status    = ST_WAITING;
    end else if (!session_r || in_delay) begin
      result.status = ST_IGNORED;
    end else if (broken) begin
      // beam broken: start timing on the first broken sample
      if (!timing_r) begin
        timing_nxt      = 1'b1;
        break_start_nxt = item.time_ms;
      end
      result.status = ST_WAITING;
    end else if (!timing_r) begin
      result.status = ST_WAITING;
    end else begin
      // beam restored: check the pulse width
      timing_nxt            = 1'b0;
      break_start_nxt       = '0;
      result.break_duration = duration;
      if (bad_width) begin
        session_nxt   = 1'b0;
        result.status = ST_TAMPER;
      end else if (cool_ok) begin
        if (counted_r != CountMax) begin
          counted_nxt = counted_r + 1'b1;
        end
        next_allowed_nxt = item.time_ms + {{(TimeW-MsW){1'b0}}, cfg.cooldown_ms};
        result.status    = ST_COUNTED;
      end else begin
        result.status = ST_COOLDOWN;
      end
    end
    result.object_count = counted_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r      <= 1'b0;
      arm_time_r     <= '0;
      timing_r       <= 1'b0;
      break_start_r  <= '0;
      next_allowed_r <= '0;
      counted_r      <= '0;
    end else if (advance) begin
      session_r      <= session_nxt;
      arm_time_r     <= arm_time_nxt;
      timing_r       <= timing_nxt;
      break_start_r  <= break_start_nxt;
      next_allowed_r <= next_allowed_nxt;
      counted_r      <= counted_nxt;
    end
  end

endmodule

// File: rtl/core/beam_pulse_object_counter.sv
// ----------------------------------------------------------------------------
// beam_pulse_object_counter: break-beam object counter with pulse-width check
//
// in_ch carries items: an arm request (req_type 0) that starts a session, or
// a sensor sample (req_type 1) with a level and a wrapping ms timestamp.
// out_ch returns exactly one result per item, in order: status, the session
// object count and the break length when the beam is restored.
// The cfg_ port writes the five threshold and timing registers; the user
// must write them only while idle, since the block does not enforce it.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while the receiver takes results, with the
// single decision stage between the two registers.
// Reset clears the session, timing, cooldown and count and loads the default
// register values; both pipeline registers come up empty.
// A stalled receiver holds the result register; the input register still
// takes one more item, and in_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
module beam_pulse_object_counter import bpoc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  bpoc_in_if.sink             in_ch,
  bpoc_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_r;
  result_t step_res;
  logic    s1_adv;
  logic    in_xfer;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_threshold <= LevelW'(512);
      cfg_r.arm_delay_ms    <= MsW'(500);
      cfg_r.min_break_ms    <= MsW'(5);
      cfg_r.max_break_ms    <= MsW'(1000);
      cfg_r.cooldown_ms     <= MsW'(100);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LEVEL_THRESHOLD: cfg_r.level_threshold <= cfg_wdata[LevelW-1:0];
        REG_ARM_DELAY_MS:    cfg_r.arm_delay_ms    <= cfg_wdata;
        REG_MIN_BREAK_MS:    cfg_r.min_break_ms    <= cfg_wdata;
        REG_MAX_BREAK_MS:    cfg_r.max_break_ms    <= cfg_wdata;
        REG_COOLDOWN_MS:     cfg_r.cooldown_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.req_type     <= in_ch.req_type;
      s1_item_r.sample_level <= in_ch.sample_level;
      s1_item_r.time_ms      <= in_ch.time_ms;
    end
  end

  // Decision logic and session state
  bpoc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= step_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.object_count   = out_r.object_count;
  assign out_ch.break_duration = out_r.break_duration;

endmodule
